/* design/length_prefixed_nal_to_start_code_top_assert.svh */
// assertion macros shared by the converter modules
// expects clk and rst_n in the scope of each use
`ifndef LENGTH_PREFIXED_NAL_TO_START_CODE_TOP_ASSERT_SVH
`define LENGTH_PREFIXED_NAL_TO_START_CODE_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define NAL2SC_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define NAL2SC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/nal2sc_pkg.sv */
// shared types and constants of the length-prefixed to start-code converter
// no dependencies
`default_nettype none

package nal2sc_pkg;

    // defaults for the top-level parameters
    localparam int START_CODE_BYTES_DEF = 4;
    localparam int SAMPLE_SIZE_BITS_DEF = 24;
    localparam int QUEUE_DEPTH_DEF      = 4;

    // fixed field widths
    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 24;
    localparam int CFG_W      = 3;
    localparam int LEN_ACC_W  = 32;

    // length prefix size limits and reset value
    localparam logic [CFG_W-1:0] PREFIX_MIN   = 3'd1;
    localparam logic [CFG_W-1:0] PREFIX_MAX   = 3'd4;
    localparam logic [CFG_W-1:0] PREFIX_RESET = 3'd4;

    // start code bytes
    localparam logic [BYTE_W-1:0] SC_ZERO_BYTE = 8'h00;
    localparam logic [BYTE_W-1:0] SC_LAST_BYTE = 8'h01;

    // one input beat
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              sample_first;
        logic [LEN_W-1:0]  sample_length;
    } in_item_t;

    // one output beat
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              unit_begin;
        logic [LEN_W-1:0]  unit_length;
        logic              first_unit_of_sample;
        logic              unit_end;
        logic              last_of_run;
    } out_item_t;

    // command from front to back: a start code burst or one payload byte
    typedef struct packed {
        logic              is_start;
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  len;
        logic              fst;
        logic              end_flag;
    } unit_cmd_t;

endpackage

`default_nettype wire

/* design/nal2sc_front.sv */
// front end: parses length prefixes and tracks sample bounds, one byte a beat
// depends on nal2sc_pkg and the assertion macro header
`default_nettype none

`include "length_prefixed_nal_to_start_code_top_assert.svh"

module nal2sc_front #(
    parameter int SAMPLE_SIZE_BITS = nal2sc_pkg::SAMPLE_SIZE_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [nal2sc_pkg::CFG_W-1:0]  cfg_wdata,
    input  wire logic                          accept,
    input  wire nal2sc_pkg::in_item_t          item,
    output      logic                          push,
    output      nal2sc_pkg::unit_cmd_t         cmd
);

    localparam int SIZE_W = SAMPLE_SIZE_BITS;
    localparam int ACC_W  = nal2sc_pkg::LEN_ACC_W;
    localparam int CFG_W  = nal2sc_pkg::CFG_W;

    typedef enum logic [1:0] {
        PH_LENGTH  = 2'b01,
        PH_PAYLOAD = 2'b10
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [CFG_W-1:0]   seen_reg, seen_next;
    logic [SIZE_W-1:0]  rem_reg, rem_next;
    logic [SIZE_W-1:0]  left_reg, left_next;
    logic               drop_reg, drop_next;
    logic               first_pend_reg, first_pend_next;
    logic [CFG_W-1:0]   cfg_reg;
    logic [CFG_W-1:0]   prefix;

    // effective prefix size, out-of-range codes clamp
    always_comb
    begin
        if (cfg_reg < nal2sc_pkg::PREFIX_MIN)
            prefix = nal2sc_pkg::PREFIX_MIN;
        else if (cfg_reg > nal2sc_pkg::PREFIX_MAX)
            prefix = nal2sc_pkg::PREFIX_MAX;
        else
            prefix = cfg_reg;
    end

    // classify the beat and compute the next parse state
    always_comb
    begin
        phase_t            ph;
        logic [ACC_W-1:0]  acc;
        logic [CFG_W-1:0]  seen;
        logic [SIZE_W-1:0] rem;
        logic [SIZE_W-1:0] left;
        logic              drop;
        logic              fp;
        logic [SIZE_W-1:0] left_dec;
        logic [SIZE_W-1:0] rem_dec;
        logic [ACC_W-1:0]  acc_new;
        logic [CFG_W-1:0]  seen_new;

        phase_next      = phase_reg;
        acc_next        = acc_reg;
        seen_next       = seen_reg;
        rem_next        = rem_reg;
        left_next       = left_reg;
        drop_next       = drop_reg;
        first_pend_next = first_pend_reg;
        push            = 1'b0;
        cmd             = '0;

        // a new sample restarts the parser
        if (item.sample_first)
        begin
            ph   = PH_LENGTH;
            acc  = '0;
            seen = '0;
            rem  = '0;
            left = SIZE_W'(item.sample_length);
            drop = 1'b0;
            fp   = 1'b1;
        end
        else
        begin
            ph   = phase_reg;
            acc  = acc_reg;
            seen = seen_reg;
            rem  = rem_reg;
            left = left_reg;
            drop = drop_reg;
            fp   = first_pend_reg;
        end

        left_dec = left - SIZE_W'(1);
        rem_dec  = (rem != '0) ? (rem - SIZE_W'(1)) : rem;
        acc_new  = {acc[ACC_W-9:0], item.data_byte};
        seen_new = seen + CFG_W'(1);

        if (accept)
        begin
            phase_next      = ph;
            acc_next        = acc;
            seen_next       = seen;
            rem_next        = rem;
            left_next       = left;
            drop_next       = drop;
            first_pend_next = fp;

            // bytes past the end of the sample are ignored
            if (left != '0)
            begin
                left_next = left_dec;
                if (!drop)
                begin
                    unique case (ph)
                        PH_PAYLOAD:
                        begin
                            rem_next     = rem_dec;
                            push         = 1'b1;
                            cmd.is_start = 1'b0;
                            cmd.data     = item.data_byte;
                            cmd.fst      = fp;
                            cmd.end_flag = (rem_dec == '0);
                            if (rem_dec == '0)
                            begin
                                phase_next      = PH_LENGTH;
                                first_pend_next = 1'b0;
                            end
                        end
                        PH_LENGTH:
                        begin
                            acc_next  = acc_new;
                            seen_next = seen_new;
                            // length field complete
                            if (seen_new >= prefix)
                            begin
                                acc_next  = '0;
                                seen_next = '0;
                                if (acc_new > ACC_W'(left_dec))
                                begin
                                    drop_next = 1'b1;
                                end
                                else
                                begin
                                    push         = 1'b1;
                                    cmd.is_start = 1'b1;
                                    cmd.len      = acc_new[nal2sc_pkg::LEN_W-1:0];
                                    cmd.fst      = fp;
                                    cmd.end_flag = (acc_new == '0);
                                    if (acc_new == '0)
                                    begin
                                        first_pend_next = 1'b0;
                                    end
                                    else
                                    begin
                                        rem_next   = SIZE_W'(acc_new);
                                        phase_next = PH_PAYLOAD;
                                    end
                                end
                            end
                        end
                        default:
                        begin
                            phase_next = PH_LENGTH;
                        end
                    endcase
                end
            end
        end
    end

    // parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_LENGTH;
            acc_reg        <= '0;
            seen_reg       <= '0;
            rem_reg        <= '0;
            left_reg       <= '0;
            drop_reg       <= 1'b0;
            first_pend_reg <= 1'b1;
        end
        else
        begin
            phase_reg      <= phase_next;
            acc_reg        <= acc_next;
            seen_reg       <= seen_next;
            rem_reg        <= rem_next;
            left_reg       <= left_next;
            drop_reg       <= drop_next;
            first_pend_reg <= first_pend_next;
        end
    end

    // length prefix size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= nal2sc_pkg::PREFIX_RESET;
        else if (cfg_we)
            cfg_reg <= cfg_wdata;
    end

    `NAL2SC_ASSERT_IMPLIES(a_payload_has_bytes, phase_reg == PH_PAYLOAD, rem_reg != '0,
        "payload phase with no bytes remaining")
    `NAL2SC_ASSERT_IMPLIES(a_drop_is_silent, accept && drop_reg && !item.sample_first,
        !push, "command issued while dropping the rest of a sample")

endmodule

`default_nettype wire

/* design/nal2sc_queue.sv */
// command queue between front and back, register-based fifo
// depends on nal2sc_pkg and the assertion macro header
`default_nettype none

`include "length_prefixed_nal_to_start_code_top_assert.svh"

module nal2sc_queue #(
    parameter int DEPTH = nal2sc_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire nal2sc_pkg::unit_cmd_t push_cmd,
    input  wire logic                  pop,
    output      logic                  not_full,
    output      logic                  not_empty,
    output      nal2sc_pkg::unit_cmd_t head
);

    // depth is a power of two, at least 2, so pointers wrap by themselves
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    nal2sc_pkg::unit_cmd_t entry_reg [DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]      count_reg, count_next;

    assign not_full  = (count_reg != CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    // pointer and fill updates
    always_comb
    begin
        wr_ptr_next = push ? (wr_ptr_reg + PTR_W'(1)) : wr_ptr_reg;
        rd_ptr_next = pop  ? (rd_ptr_reg + PTR_W'(1)) : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    `NAL2SC_ASSERT_IMPLIES(a_fill_in_range, 1'b1, count_reg <= CNT_W'(DEPTH),
        "queue fill count beyond depth")

endmodule

`default_nettype wire

/* design/nal2sc_back.sv */
// back end: expands queued commands into output beats behind an output register
// depends on nal2sc_pkg and the assertion macro header
`default_nettype none

`include "length_prefixed_nal_to_start_code_top_assert.svh"

module nal2sc_back #(
    parameter int START_CODE_BYTES = nal2sc_pkg::START_CODE_BYTES_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  head_valid,
    input  wire nal2sc_pkg::unit_cmd_t head,
    output      logic                  pop,
    output      logic                  conv_valid,
    input  wire logic                  conv_ready,
    output      nal2sc_pkg::out_item_t conv_item
);

    localparam int IDX_W = $clog2(START_CODE_BYTES);

    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic                  valid_reg, valid_next;
    nal2sc_pkg::out_item_t out_reg, out_next;
    logic                  adv;
    logic                  sc_last;
    logic                  last_beat;

    assign conv_valid = valid_reg;
    assign conv_item  = out_reg;

    // one beat leaves the queue head whenever the output register frees up
    assign adv       = head_valid && (!valid_reg || conv_ready);
    assign sc_last   = (idx_reg == IDX_W'(START_CODE_BYTES - 1));
    assign last_beat = !head.is_start || sc_last;
    assign pop       = adv && last_beat;

    // beat contents
    always_comb
    begin
        out_next = '0;
        if (head.is_start)
        begin
            out_next.out_byte    = sc_last ? nal2sc_pkg::SC_LAST_BYTE
                                           : nal2sc_pkg::SC_ZERO_BYTE;
            out_next.unit_begin  = (idx_reg == '0);
            out_next.unit_length = (idx_reg == '0) ? head.len : '0;
            out_next.unit_end    = sc_last && head.end_flag;
            out_next.last_of_run = sc_last;
        end
        else
        begin
            out_next.out_byte    = head.data;
            out_next.unit_end    = head.end_flag;
            out_next.last_of_run = 1'b1;
        end
        out_next.first_unit_of_sample = head.fst;
    end

    // sequencer and output valid
    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (adv)
        begin
            idx_next   = last_beat ? '0 : (idx_reg + IDX_W'(1));
            valid_next = 1'b1;
        end
        else if (conv_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // output payload register
    always_ff @(posedge clk)
    begin
        if (adv)
            out_reg <= out_next;
    end

    `NAL2SC_ASSERT_IMPLIES(a_burst_has_head, idx_reg != '0, head_valid && head.is_start,
        "start code burst in progress without a start command at the head")
    `NAL2SC_ASSERT_NEXT(a_pop_rewinds, pop, idx_reg == '0,
        "beat index not rewound after a command left the queue")

endmodule

`default_nettype wire

/* design/length_prefixed_nal_to_start_code_top.sv */
// channel  | direction | handshake                  | beat
// byte     | in        | byte_valid / byte_ready    | byte_item (nal2sc_pkg::in_item_t)
// conv     | out       | conv_valid / conv_ready    | conv_item (nal2sc_pkg::out_item_t)
// cfg      | in        | cfg_we, no wait            | cfg_wdata (length prefix bytes)
//
// the front takes one input beat a cycle while the command queue has room
// a payload byte gives one output beat, a unit start gives START_CODE_BYTES beats;
// the queue of QUEUE_DEPTH commands and the output register absorb that burst
// an input beat's command is registered in the queue, then its output beat in the output register
// rst_n clears parse state, queue and output valid; prefix size resets to 4 bytes
// top level of the converter; depends on nal2sc_pkg, nal2sc_front, nal2sc_queue,
// nal2sc_back
`default_nettype none

module length_prefixed_nal_to_start_code_top #(
    parameter int START_CODE_BYTES = nal2sc_pkg::START_CODE_BYTES_DEF,
    parameter int SAMPLE_SIZE_BITS = nal2sc_pkg::SAMPLE_SIZE_BITS_DEF,
    parameter int QUEUE_DEPTH      = nal2sc_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [nal2sc_pkg::CFG_W-1:0] cfg_wdata,
    input  wire logic                         byte_valid,
    output      logic                         byte_ready,
    input  wire nal2sc_pkg::in_item_t         byte_item,
    output      logic                         conv_valid,
    input  wire logic                         conv_ready,
    output      nal2sc_pkg::out_item_t        conv_item
);

    logic                  accept;
    logic                  push;
    logic                  pop;
    logic                  not_full;
    logic                  not_empty;
    nal2sc_pkg::unit_cmd_t push_cmd;
    nal2sc_pkg::unit_cmd_t head;

    // input beat taken while the queue has room for its command
    assign byte_ready = not_full;
    assign accept     = byte_valid && not_full;

    nal2sc_front #(
        .SAMPLE_SIZE_BITS (SAMPLE_SIZE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .item      (byte_item),
        .push      (push),
        .cmd       (push_cmd)
    );

    nal2sc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .not_full  (not_full),
        .not_empty (not_empty),
        .head      (head)
    );

    nal2sc_back #(
        .START_CODE_BYTES (START_CODE_BYTES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (not_empty),
        .head       (head),
        .pop        (pop),
        .conv_valid (conv_valid),
        .conv_ready (conv_ready),
        .conv_item  (conv_item)
    );

endmodule

`default_nettype wire

/* tb/sv/tb_length_prefixed_nal_to_start_code_top.sv */
`timescale 1ns / 100ps
// self-checking testbench of the length-prefixed to start-code converter
// a predictor of the conversion checks every output beat; depends on nal2sc_pkg
// and length_prefixed_nal_to_start_code_top

module tb_length_prefixed_nal_to_start_code_top;

    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 8;
    localparam int SC_BYTES     = nal2sc_pkg::START_CODE_BYTES_DEF;
    localparam int BYTE_W       = nal2sc_pkg::BYTE_W;
    localparam int CFG_W        = nal2sc_pkg::CFG_W;
    localparam int LEN_W        = nal2sc_pkg::LEN_W;
    localparam int LEN_ACC_W    = nal2sc_pkg::LEN_ACC_W;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef enum logic {PARSE_LENGTH, PARSE_PAYLOAD} parse_phase_t;
    typedef enum logic {RX_ALWAYS, RX_PATTERN} rx_mode_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_W-1:0]      cfg_wdata;
    logic                  byte_valid;
    logic                  byte_ready;
    nal2sc_pkg::in_item_t  byte_item;
    logic                  conv_valid;
    logic                  conv_ready;
    nal2sc_pkg::out_item_t conv_item;

    // predictor state
    logic [CFG_W-1:0]     prefix_cfg;
    parse_phase_t         parse_phase;
    logic [LEN_ACC_W-1:0] len_acc;
    logic [2:0]           len_seen;
    logic [31:0]          pay_left;
    logic [LEN_W-1:0]     consumed;
    logic [LEN_W-1:0]     held_size;
    logic                 drop_rest;
    logic                 first_pending;

    nal2sc_pkg::out_item_t conv_expect[$];
    int        mismatch_count = 0;
    int        items_sent = 0;
    int        burst_left = 0;
    bit        tx_bursty = 1'b0;
    rx_mode_t  rx_mode = RX_PATTERN;
    int        hold_off_cycles = 0;

    length_prefixed_nal_to_start_code_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_item  (byte_item),
        .conv_valid (conv_valid),
        .conv_ready (conv_ready),
        .conv_item  (conv_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // prefix size as the block applies it
    function automatic int prefix_bytes_eff();
        if (prefix_cfg < nal2sc_pkg::PREFIX_MIN)
            return int'(nal2sc_pkg::PREFIX_MIN);
        if (prefix_cfg > nal2sc_pkg::PREFIX_MAX)
            return int'(nal2sc_pkg::PREFIX_MAX);
        return int'(prefix_cfg);
    endfunction

    task automatic reset_predictor();
        prefix_cfg    = nal2sc_pkg::PREFIX_RESET;
        parse_phase   = PARSE_LENGTH;
        len_acc       = '0;
        len_seen      = '0;
        pay_left      = '0;
        consumed      = '0;
        held_size     = '0;
        drop_rest     = 1'b0;
        first_pending = 1'b1;
    endtask

    // expected output beats for one accepted input beat
    task automatic predict_conversion(input nal2sc_pkg::in_item_t it);
        nal2sc_pkg::out_item_t r;
        logic [31:0]           left;
        int                    i;
        if (it.sample_first)
        begin
            parse_phase   = PARSE_LENGTH;
            len_acc       = '0;
            len_seen      = '0;
            pay_left      = '0;
            consumed      = '0;
            held_size     = it.sample_length;
            drop_rest     = 1'b0;
            first_pending = 1'b1;
        end
        // bytes past the sample end are ignored
        if (consumed >= held_size)
            return;
        consumed = consumed + LEN_W'(1);
        if (drop_rest)
            return;
        // payload byte passes through
        if (parse_phase == PARSE_PAYLOAD)
        begin
            r = '0;
            r.out_byte             = it.data_byte;
            r.first_unit_of_sample = first_pending;
            r.last_of_run          = 1'b1;
            if (pay_left > 0)
                pay_left = pay_left - 32'd1;
            if (pay_left == 0)
            begin
                r.unit_end    = 1'b1;
                parse_phase   = PARSE_LENGTH;
                first_pending = 1'b0;
            end
            conv_expect.push_back(r);
            return;
        end
        // length field byte, big-endian
        len_acc  = {len_acc[LEN_ACC_W-BYTE_W-1:0], it.data_byte};
        len_seen = len_seen + 3'd1;
        if (int'(len_seen) < prefix_bytes_eff())
            return;
        len_seen = '0;
        left = {8'd0, held_size} - {8'd0, consumed};
        // unit runs past the sample end: drop the rest of the sample
        if (len_acc > left)
        begin
            drop_rest = 1'b1;
            len_acc   = '0;
            return;
        end
        for (i = 0; i < SC_BYTES; i++)
        begin
            r = '0;
            r.out_byte             = (i == SC_BYTES - 1) ? nal2sc_pkg::SC_LAST_BYTE
                                                         : nal2sc_pkg::SC_ZERO_BYTE;
            r.unit_begin           = (i == 0);
            r.unit_length          = (i == 0) ? len_acc[LEN_W-1:0] : '0;
            r.first_unit_of_sample = first_pending;
            r.unit_end             = (i == SC_BYTES - 1) && (len_acc == 0);
            r.last_of_run          = (i == SC_BYTES - 1);
            conv_expect.push_back(r);
        end
        if (len_acc == 0)
            first_pending = 1'b0;
        else
        begin
            pay_left    = len_acc;
            parse_phase = PARSE_PAYLOAD;
        end
        len_acc = '0;
    endtask

    // one input beat, with a random gap before each new burst when the sender is bursty
    task automatic send_beat(input byte_t b, input logic first, input logic [LEN_W-1:0] slen);
        nal2sc_pkg::in_item_t it;
        int                   gap;
        if (tx_bursty && burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                byte_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        it.data_byte     = b;
        it.sample_first  = first;
        it.sample_length = slen;
        byte_item  <= it;
        byte_valid <= 1'b1;
        do
            @(posedge clk);
        while (!byte_ready);
        predict_conversion(it);
        if (burst_left > 0)
            burst_left--;
        items_sent++;
    endtask

    // length prefix of p bytes followed by npay random payload bytes
    task automatic append_unit(ref byte_t q[$], input int p, input logic [31:0] stated,
                               input int npay);
        int k;
        for (k = p - 1; k >= 0; k--)
            q.push_back(stated[8*k +: 8]);
        repeat (npay) q.push_back(byte_t'($urandom_range(0, 255)));
    endtask

    // first beat carries the sample size, the others random noise in that field
    task automatic send_sample(ref byte_t q[$], input logic [LEN_W-1:0] size);
        foreach (q[i])
            send_beat(q[i], i == 0, (i == 0) ? size : LEN_W'($urandom_range(0, 24'hFFFFFF)));
    endtask

    // stop offering beats and wait until every expected beat is out
    task automatic wait_drained();
        byte_valid <= 1'b0;
        while (conv_expect.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_prefix_cfg(input logic [CFG_W-1:0] v);
        wait_drained();
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        prefix_cfg = v;
    endtask

    // mostly well-formed samples; some truncated, overrunning or oversized
    task automatic random_sample();
        byte_t            q[$];
        int               p;
        int               kind;
        int               npay;
        logic [LEN_W-1:0] size;
        p    = prefix_bytes_eff();
        kind = $urandom_range(0, 9);
        repeat ($urandom_range(1, 3))
        begin
            npay = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 24) : $urandom_range(0, 5);
            append_unit(q, p, npay, npay);
        end
        size = LEN_W'(q.size());
        if (kind == 7)
            size = LEN_W'($urandom_range(0, q.size()));
        else if (kind == 8)
        begin
            append_unit(q, p, $urandom_range(3, 60), $urandom_range(0, 2));
            size = LEN_W'(q.size());
        end
        else if (kind == 9)
            size = LEN_W'(q.size() + $urandom_range(1, 2000));
        send_sample(q, size);
    endtask

    task automatic test_before_first_sample();
        send_beat(8'hFF, 1'b0, 24'hFFFFFF);
    endtask

    task automatic test_zero_and_short_units();
        byte_t q[$];
        append_unit(q, 4, 0, 0);
        append_unit(q, 4, 1, 1);
        send_sample(q, LEN_W'(q.size()));
        send_beat(8'h00, 1'b0, 24'h000000);
    endtask

    task automatic test_one_byte_prefix();
        byte_t q[$];
        write_prefix_cfg(3'd1);
        append_unit(q, 1, 1, 1);
        append_unit(q, 1, 255, 0);
        q.push_back(8'h00);
        send_sample(q, LEN_W'(q.size()));
    endtask

    task automatic test_sample_ends_in_prefix();
        byte_t q[$];
        write_prefix_cfg(3'd7);
        append_unit(q, 4, 0, 0);
        q.push_back(8'hFF);
        q.push_back(8'hFF);
        send_sample(q, LEN_W'(q.size()));
    endtask

    task automatic test_new_sample_mid_unit();
        byte_t q[$];
        append_unit(q, 4, 32'h00FF_FFF0, 1);
        send_sample(q, 24'hFFFFFF);
    endtask

    task automatic test_empty_sample();
        send_beat(8'hAA, 1'b1, 24'h000000);
        send_beat(8'h55, 1'b0, 24'h000001);
    endtask

    task automatic test_prefix_write_mid_field();
        write_prefix_cfg(3'd3);
        send_beat(8'h00, 1'b1, 24'd5);
        // the shorter prefix applies to the field already started
        write_prefix_cfg(3'd0);
        send_beat(8'h02, 1'b0, 24'h000000);
        send_beat(8'h5A, 1'b0, 24'h000000);
        send_beat(8'hA5, 1'b0, 24'h000000);
        send_beat(8'h00, 1'b0, 24'h000000);
    endtask

    task automatic test_output_hold_off();
        byte_t q[$];
        wait_drained();
        rx_mode = RX_ALWAYS;
        tx_bursty = 1'b0;
        hold_off_cycles = 80;
        repeat (3) append_unit(q, prefix_bytes_eff(), 6, 6);
        send_sample(q, LEN_W'(q.size()));
    endtask

    task automatic test_random_samples();
        logic [CFG_W-1:0] cfg_list[8];
        int               base;
        cfg_list = '{3'd2, 3'd1, 3'd4, 3'd3, 3'd0, 3'd5, 3'd6, 3'd2};
        foreach (cfg_list[i])
        begin
            write_prefix_cfg(cfg_list[i]);
            tx_bursty = (i % 3 != 0);
            rx_mode   = (i % 3 == 1) ? RX_ALWAYS : RX_PATTERN;
            base      = items_sent;
            while (items_sent < base + 32)
                random_sample();
        end
    endtask

    // output side: runs of ready and stalls, plus an occasional long hold-off
    initial
    begin : receiver
        int run;
        int hold;
        bit stalling;
        run = 0;
        hold = 0;
        stalling = 1'b0;
        conv_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles > 0)
            begin
                hold = hold_off_cycles;
                hold_off_cycles = 0;
            end
            if (hold > 0)
            begin
                hold--;
                conv_ready <= 1'b0;
            end
            else if (rx_mode == RX_ALWAYS)
                conv_ready <= 1'b1;
            else
            begin
                if (run == 0)
                begin
                    stalling = !stalling;
                    run = stalling ? $urandom_range(1, 4) : $urandom_range(1, 10);
                end
                run--;
                conv_ready <= !stalling;
            end
        end
    end

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    // compare each output beat with the oldest expectation
    initial
    begin : conv_checker
        nal2sc_pkg::out_item_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && conv_valid && conv_ready)
            begin
                if (conv_expect.size() == 0)
                begin
                    $error("unexpected beat: out_byte %0h", conv_item.out_byte);
                    mismatch_count++;
                end
                else
                begin
                    want = conv_expect.pop_front();
                    compare_field("out_byte", 32'(want.out_byte), 32'(conv_item.out_byte));
                    compare_field("unit_begin", 32'(want.unit_begin),
                                  32'(conv_item.unit_begin));
                    compare_field("unit_length", 32'(want.unit_length),
                                  32'(conv_item.unit_length));
                    compare_field("first_unit_of_sample", 32'(want.first_unit_of_sample),
                                  32'(conv_item.first_unit_of_sample));
                    compare_field("unit_end", 32'(want.unit_end), 32'(conv_item.unit_end));
                    compare_field("last_of_run", 32'(want.last_of_run),
                                  32'(conv_item.last_of_run));
                end
            end
        end
    end

    // ends the run when no beat moves on either channel for too long
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((byte_valid && byte_ready) || (conv_valid && conv_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        rst_n      <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_wdata  <= nal2sc_pkg::PREFIX_RESET;
        byte_valid <= 1'b0;
        byte_item  <= '0;
        reset_predictor();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_before_first_sample();
        test_zero_and_short_units();
        test_one_byte_prefix();
        test_sample_ends_in_prefix();
        test_new_sample_mid_unit();
        test_empty_sample();
        test_prefix_write_mid_field();
        test_output_hold_off();
        test_random_samples();

        // let late or stray beats show up
        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
